[src/i8mm_pkg.sv]
// Shared definitions for the int8 matrix-vector requantization core.
// Holds op codes, register indexes, width helpers and the controller/datapath types.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package i8mm_pkg;

	// Default sizes of the weight matrix.
	localparam int CHANNELS_DEF   = 16;
	localparam int REDUCE_MAX_DEF = 256;

	// Configuration port.
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_LEN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_ZERO_POINT = 2'd2;

	localparam logic [6:0]        NUM_CHANNELS_RST   = 7'd16;
	localparam logic [8:0]        REDUCE_LEN_RST     = 9'd1;
	localparam logic signed [7:0] OUT_ZERO_POINT_RST = 8'sd0;

	// Input word op codes. The fourth code is ignored.
	localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
	localparam logic [1:0] OP_LOAD_PARAM  = 2'd1;
	localparam logic [1:0] OP_ACTIVATION  = 2'd2;

	// Bits needed to index a store of the given depth.
	function automatic int idx_width(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// Bits needed to hold a reduction length up to rmax, and the 9-bit register.
	function automatic int len_width(input int rmax);
		int w;
		w = $clog2(rmax + 1);
		return (w > 9) ? w : 9;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_RQ_READ,
		ST_RQ_MUL,
		ST_RQ_ROUND,
		ST_RQ_OUT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // input word taken this cycle
		logic mac_issue;   // read weight and accumulator of the current channel
		logic pos_advance; // step the reduction position at the end of an element
		logic rq_mul;      // register accumulator times multiplier
		logic rq_round;    // register the rounded shift result
		logic out_load;    // load the output register
		logic out_last;    // result being loaded belongs to the last channel
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic col_end;  // current element is the last of its column
		logic out_free; // output register can take a word this cycle
	} dp_status_t;

endpackage

`default_nettype wire

[src/i8mm_ctrl.sv]
// Controller state machine of the int8 matrix-vector requantization core.
// Walks the channels for the accumulate and requantize phases and drives the datapath.
// Depends on i8mm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i8mm_ctrl #(
	parameter int CHANNELS = i8mm_pkg::CHANNELS_DEF,
	localparam int CH_W = i8mm_pkg::idx_width(CHANNELS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  logic [CH_W-1:0]        nch_last,
	input  i8mm_pkg::dp_status_t   status,
	output i8mm_pkg::dp_cmd_t      cmd,
	output logic [CH_W-1:0]        chan_idx
);

	import i8mm_pkg::*;

	ctrl_state_t     state_q;
	ctrl_state_t     state_d;
	logic [CH_W-1:0] chan_q;
	logic [CH_W-1:0] chan_d;
	logic            at_last;

	assign at_last  = (chan_q == nch_last);
	assign chan_idx = chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chan_q  <= '0;
		end else begin
			state_q <= state_d;
			chan_q  <= chan_d;
		end
	end

	// Next state and channel counter.
	always_comb begin
		state_d = state_q;
		chan_d  = chan_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && (op == OP_ACTIVATION)) begin
					state_d = ST_MAC;
					chan_d  = '0;
				end
			end
			ST_MAC: begin
				if (at_last) begin
					state_d = ST_DRAIN;
				end else begin
					chan_d = chan_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (status.col_end) begin
					state_d = ST_RQ_READ;
					chan_d  = '0;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RQ_READ:  state_d = ST_RQ_MUL;
			ST_RQ_MUL:   state_d = ST_RQ_ROUND;
			ST_RQ_ROUND: state_d = ST_RQ_OUT;
			ST_RQ_OUT: begin
				if (status.out_free) begin
					if (at_last) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_RQ_READ;
						chan_d  = chan_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_MAC:      cmd.mac_issue   = 1'b1;
			ST_DRAIN:    cmd.pos_advance = 1'b1;
			ST_RQ_READ:  cmd             = '0;
			ST_RQ_MUL:   cmd.rq_mul      = 1'b1;
			ST_RQ_ROUND: cmd.rq_round    = 1'b1;
			ST_RQ_OUT: begin
				cmd.out_load = status.out_free;
				cmd.out_last = at_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

[src/i8mm_dp.sv]
// Datapath of the int8 matrix-vector requantization core.
// Holds the weight, channel parameter and accumulator stores, the shared 8x8 MAC,
// the 32x32 requantization multiplier, rounding, saturation and the output register.
// Depends on i8mm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i8mm_dp #(
	parameter int CHANNELS   = i8mm_pkg::CHANNELS_DEF,
	parameter int REDUCE_MAX = i8mm_pkg::REDUCE_MAX_DEF,
	localparam int CH_W  = i8mm_pkg::idx_width(CHANNELS),
	localparam int LEN_W = i8mm_pkg::len_width(REDUCE_MAX)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i8mm_pkg::dp_cmd_t     cmd,
	output i8mm_pkg::dp_status_t  status,
	input  logic [CH_W-1:0]       chan_idx,
	input  logic [LEN_W-1:0]      len_eff,
	input  logic signed [7:0]     zero_point,
	input  logic [1:0]            op,
	input  logic [5:0]            chan,
	input  logic [7:0]            pos,
	input  logic signed [7:0]     weight,
	input  logic signed [31:0]    bias,
	input  logic signed [31:0]    multiplier,
	input  logic signed [5:0]     shift_code,
	input  logic signed [7:0]     activation,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic signed [7:0]     out_value,
	output logic [5:0]            out_chan,
	output logic                  out_last
);

	import i8mm_pkg::*;

	localparam int DEPTH = CHANNELS * REDUCE_MAX;
	localparam int AW    = idx_width(DEPTH);
	localparam int CNT_W = idx_width(REDUCE_MAX);

	localparam logic [6:0]    CH_LIM  = 7'(CHANNELS);
	localparam logic [12:0]   POS_LIM = 13'(REDUCE_MAX);
	localparam logic [AW-1:0] ROW     = AW'(REDUCE_MAX);

	// Stores.
	logic signed [7:0] wgt_mem   [DEPTH];
	logic [31:0]       bias_mem  [CHANNELS];
	logic [31:0]       mult_mem  [CHANNELS];
	logic [4:0]        shift_mem [CHANNELS];
	logic [31:0]       acc_mem   [CHANNELS];
	logic [CHANNELS-1:0] acc_vld_q;

	// Registered read data.
	logic signed [7:0]  wgt_rd_q;
	logic signed [31:0] bias_rd_q;
	logic signed [31:0] mult_rd_q;
	logic [4:0]         shift_rd_q;
	logic signed [31:0] acc_rd_q;
	logic               vld_rd_q;

	logic               chan_ok;
	logic               pos_ok;
	logic               wgt_we;
	logic               par_we;
	logic [CH_W-1:0]    ld_idx;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;

	logic [CNT_W-1:0]   pos_cnt_q;
	logic signed [7:0]  act_q;
	logic               mac_s1;
	logic [CH_W-1:0]    chan_s1;
	logic signed [15:0] mac_prod;
	logic signed [31:0] acc_cur;
	logic signed [31:0] acc_base;
	logic [31:0]        acc_sum;
	logic               first_pos;

	logic signed [63:0] prod_q;
	logic [4:0]         shift_q;
	logic signed [31:0] hi;
	logic signed [32:0] rnd_add;
	logic signed [32:0] rnd_sum;
	logic signed [32:0] rnd_shr;
	logic signed [31:0] rnd_q;
	logic signed [32:0] zsum;
	logic signed [7:0]  sat_val;

	logic               out_valid_q;
	logic signed [7:0]  out_value_q;
	logic [5:0]         out_chan_q;
	logic               out_last_q;

	// Load decode; loads outside the store are dropped.
	assign chan_ok = ({1'b0, chan} < CH_LIM);
	assign pos_ok  = ({5'b0, pos} < POS_LIM);
	assign wgt_we  = cmd.accept && (op == OP_LOAD_WEIGHT) && chan_ok && pos_ok;
	assign par_we  = cmd.accept && (op == OP_LOAD_PARAM) && chan_ok;
	assign ld_idx  = chan[CH_W-1:0];
	assign wr_addr = AW'(ld_idx) * ROW + AW'(pos);
	assign rd_addr = AW'(chan_idx) * ROW + AW'(pos_cnt_q);

	always_ff @(posedge clk) begin
		if (wgt_we) begin
			wgt_mem[wr_addr] <= weight;
		end
		wgt_rd_q <= wgt_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			bias_mem[ld_idx]  <= bias;
			mult_mem[ld_idx]  <= multiplier;
			shift_mem[ld_idx] <= ~shift_code[4:0];
		end
		bias_rd_q  <= bias_mem[chan_idx];
		mult_rd_q  <= mult_mem[chan_idx];
		shift_rd_q <= shift_mem[chan_idx];
	end

	always_ff @(posedge clk) begin
		if (mac_s1) begin
			acc_mem[chan_s1] <= acc_sum;
		end
		acc_rd_q <= acc_mem[chan_idx];
		vld_rd_q <= acc_vld_q[chan_idx];
	end

	// An accumulator never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
		end else if (mac_s1) begin
			acc_vld_q[chan_s1] <= 1'b1;
		end
	end

	// Reduction position within the current column.
	assign status.col_end = ((LEN_W'(pos_cnt_q) + LEN_W'(1)) >= len_eff);
	assign first_pos      = (pos_cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cnt_q <= '0;
			mac_s1    <= 1'b0;
		end else begin
			mac_s1 <= cmd.mac_issue;
			if (cmd.pos_advance) begin
				pos_cnt_q <= status.col_end ? '0 : pos_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (op == OP_ACTIVATION)) begin
			act_q <= activation;
		end
		chan_s1 <= chan_idx;
	end

	// Multiply-accumulate, one channel per cycle.
	assign mac_prod = wgt_rd_q * act_q;
	assign acc_cur  = vld_rd_q ? acc_rd_q : 32'sd0;
	assign acc_base = first_pos ? bias_rd_q : acc_cur;
	assign acc_sum  = acc_base + {{16{mac_prod[15]}}, mac_prod};

	// Requantization: high word of the product, rounding shift, zero point, saturation.
	assign hi      = prod_q[63:32];
	assign rnd_add = (shift_q == 5'd0) ? 33'sd0 : (33'sd1 <<< (shift_q - 5'd1));
	assign rnd_sum = {hi[31], hi} + rnd_add;
	assign rnd_shr = rnd_sum >>> shift_q;
	assign zsum    = {rnd_q[31], rnd_q} + {{25{zero_point[7]}}, zero_point};

	always_comb begin
		if (zsum > 33'sd127) begin
			sat_val = 8'sd127;
		end else if (zsum < -33'sd128) begin
			sat_val = -8'sd128;
		end else begin
			sat_val = zsum[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rq_mul) begin
			prod_q  <= acc_cur * mult_rd_q;
			shift_q <= shift_rd_q;
		end
		if (cmd.rq_round) begin
			rnd_q <= rnd_shr[31:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q <= sat_val;
			out_chan_q  <= 6'(chan_idx);
			out_last_q  <= cmd.out_last;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_value       = out_value_q;
	assign out_chan        = out_chan_q;
	assign out_last        = out_last_q;

endmodule

`default_nettype wire

[src/int8_matmul_requantize_core.sv]
// Top level of the int8 matrix-vector core with per-channel requantization.
// Holds the configuration registers and joins the controller and the datapath.
// Depends on i8mm_pkg, i8mm_ctrl and i8mm_dp.
`timescale 1ns / 1ps
`default_nettype none

// The core keeps an int8 weight matrix of CHANNELS rows by REDUCE_MAX positions and,
// per channel, a 32-bit bias, a 32-bit multiplier and a 5-bit right shift. Input words
// either load one weight (op 0), load one channel's parameters (op 1) or carry one
// activation element of the current column (op 2); op 3 is dropped. A load word is taken
// in the idle state, so loads stream at one word per clock. An activation word walks the
// active channels through a single shared 8x8 multiply-accumulate fed by the single-read
// weight and accumulator memories, one channel per cycle, and the next word is taken only
// after a drain state steps the reduction position. On the first element of a column each
// accumulator starts from its channel's bias; on the last element the core also
// requantizes every active channel in channel order: the accumulator times the multiplier
// on a 32x32 multiplier, the high word shifted right with round-half-up, the output zero
// point added and the value saturated to int8. That phase steps each channel through the
// read, multiply, round and output states of the one multiplier and rounding path, waiting
// while the output side stalls, and out_last marks the last active channel. The output
// register lets the last result of a column wait while new words are already being taken.
// No store needs a clearing pass after reset; weights and channel parameters
// must be loaded before use. Configuration may only be written while the core is idle.
module int8_matmul_requantize_core #(
	parameter int CHANNELS   = i8mm_pkg::CHANNELS_DEF,
	parameter int REDUCE_MAX = i8mm_pkg::REDUCE_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [i8mm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [i8mm_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      op,
	input  logic [5:0]                      chan,
	input  logic [7:0]                      pos,
	input  logic signed [7:0]               weight,
	input  logic signed [31:0]              bias,
	input  logic signed [31:0]              multiplier,
	input  logic signed [5:0]               shift_code,
	input  logic signed [7:0]               activation,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [7:0]               out_value,
	output logic [5:0]                      out_chan,
	output logic                            out_last
);

	import i8mm_pkg::*;

	localparam int CH_W  = idx_width(CHANNELS);
	localparam int LEN_W = len_width(REDUCE_MAX);

	localparam logic [6:0]       CH_MAX   = 7'(CHANNELS);
	localparam logic [CH_W-1:0]  CH_TOP   = CH_W'(CHANNELS - 1);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(REDUCE_MAX);

	logic [6:0]        num_channels_q;
	logic [8:0]        reduce_len_q;
	logic signed [7:0] out_zero_point_q;

	logic [CH_W-1:0]   nch_last;
	logic [LEN_W-1:0]  len_ext;
	logic [LEN_W-1:0]  len_eff;
	logic [CH_W-1:0]   chan_idx;
	dp_cmd_t           cmd;
	dp_status_t        status;

	// Configuration registers. Writes to the unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_channels_q   <= NUM_CHANNELS_RST;
			reduce_len_q     <= REDUCE_LEN_RST;
			out_zero_point_q <= OUT_ZERO_POINT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_CHANNELS:   num_channels_q   <= cfg_data[6:0];
				CFG_REDUCE_LEN:     reduce_len_q     <= cfg_data;
				CFG_OUT_ZERO_POINT: out_zero_point_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// A channel count of zero acts as one, and a count above the array size as
	// the full array; the reduction length is clamped the same way.
	always_comb begin
		if (num_channels_q == 7'd0) begin
			nch_last = '0;
		end else if (num_channels_q > CH_MAX) begin
			nch_last = CH_TOP;
		end else begin
			nch_last = CH_W'(num_channels_q - 7'd1);
		end
	end

	assign len_ext = LEN_W'(reduce_len_q);

	always_comb begin
		if (reduce_len_q == 9'd0) begin
			len_eff = LEN_W'(1);
		end else if (len_ext > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = len_ext;
		end
	end

	i8mm_ctrl #(
		.CHANNELS (CHANNELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.nch_last (nch_last),
		.status   (status),
		.cmd      (cmd),
		.chan_idx (chan_idx)
	);

	i8mm_dp #(
		.CHANNELS   (CHANNELS),
		.REDUCE_MAX (REDUCE_MAX)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.chan_idx   (chan_idx),
		.len_eff    (len_eff),
		.zero_point (out_zero_point_q),
		.op         (op),
		.chan       (chan),
		.pos        (pos),
		.weight     (weight),
		.bias       (bias),
		.multiplier (multiplier),
		.shift_code (shift_code),
		.activation (activation),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_value  (out_value),
		.out_chan   (out_chan),
		.out_last   (out_last)
	);

endmodule

`default_nettype wire

[src/i8mm_checker.sv]
// Port-level checks for the int8 matrix-vector requantization core, with its bind.
// Depends on i8mm_pkg and the top level int8_matmul_requantize_core.
`timescale 1ns / 1ps
`default_nettype none

module i8mm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        op,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [7:0] out_value,
	input logic [5:0]        out_chan,
	input logic              out_last
);

	import i8mm_pkg::*;

	// A result word that is not taken holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_chan)
			&& $stable(out_last))
	else $error("stalled result word changed");

	// While a column's results are still being produced no input word is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
	else $error("input taken in the middle of a column's results");

	// An activation word keeps the core busy for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_ACTIVATION) |=> !in_ready)
	else $error("core ready right after an activation word");

	// Load and unused words finish in the cycle they are taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op != OP_ACTIVATION) |=> in_ready)
	else $error("core not ready after a load word");

endmodule

bind int8_matmul_requantize_core i8mm_checker u_i8mm_checker (.*);

`default_nettype wire
